FILE: rtl/pcm_byte_stream_to_stereo_defines.svh
// Assertion macros shared by the PCM byte stream to stereo checks.
`ifndef PCM_BYTE_STREAM_TO_STEREO_DEFINES_SVH
`define PCM_BYTE_STREAM_TO_STEREO_DEFINES_SVH

// Check a consequence in the same cycle, outside reset.
`define PBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcm stream check failed");

// Check a consequence in the next cycle, outside reset.
`define PBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcm stream check failed");

// Check a consequence in the next cycle, reset included.
`define PBS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pcm stream reset check failed");

`endif

FILE: rtl/pbs_pkg.sv
// Shared types, codes and helper functions of the PCM byte stream to stereo block.
package pbs_pkg;

  // Sample format codes
  localparam logic [2:0] FMT_S16 = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_F32 = 3'd2;
  localparam logic [2:0] FMT_S24 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;

  // Register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

  // Channel limits
  localparam int MAX_CHANNELS = 8;
  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_W = 5;

  typedef logic signed [31:0] sample_t;

  typedef struct packed {
    logic    emit;
    sample_t left;
    sample_t right;
  } frame_t;

  // Bytes per sample; unused codes read as signed16
  function automatic logic [2:0] bytes_per_sample(input logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_U8:  n = 3'd1;
      FMT_F32: n = 3'd4;
      FMT_S24: n = 3'd3;
      FMT_S32: n = 3'd4;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  // Channels per frame: zero reads as two, large values saturate
  function automatic logic [CH_W-1:0] channels_in_use(input logic [3:0] cnt);
    logic [CH_W-1:0] c;
    c = {1'b0, cnt};
    if (cnt == 4'd0) begin
      c = CH_W'(2);
    end else if (c > CH_W'(MAX_CHANNELS)) begin
      c = CH_W'(MAX_CHANNELS);
    end
    return c;
  endfunction

endpackage

FILE: rtl/pbs_to_q31.sv
// Normalizes one assembled raw sample to Q1.31 for the configured format.
module pbs_to_q31 import pbs_pkg::*; (
  input  logic [2:0]  fmt,
  input  logic [31:0] raw,
  output sample_t     q
);

  logic        neg;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [23:0] mant;
  logic [7:0]  up_sh;
  logic [7:0]  dn_sh;
  logic [24:0] rnd;
  logic [31:0] mag;
  logic [31:0] fq;

  // Convert float bits: saturate, NaN and tiny values to zero, round half away from zero
  always_comb begin
    neg   = raw[31];
    ex    = raw[30:23];
    man   = raw[22:0];
    mant  = {1'b1, man};
    up_sh = ex - 8'd119;
    dn_sh = 8'd119 - ex;
    rnd   = '0;
    mag   = '0;
    if (ex == 8'hFF && man != 23'd0) begin
      fq = 32'h0;
    end else if (ex >= 8'd127) begin
      fq = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (ex == 8'd0) begin
      fq = 32'h0;
    end else begin
      if (ex >= 8'd119) begin
        mag = {8'h0, mant} << up_sh[2:0];
      end else if (dn_sh >= 8'd25) begin
        mag = 32'h0;
      end else begin
        rnd = ({1'b0, mant} + (25'd1 << (dn_sh[4:0] - 5'd1))) >> dn_sh[4:0];
        mag = {7'h0, rnd};
      end
      fq = neg ? (32'h0 - mag) : mag;
    end
  end

  // Pick the scaling of the format
  always_comb begin
    case (fmt)
      FMT_U8:  q = {~raw[7], raw[6:0], 24'h0};
      FMT_F32: q = fq;
      FMT_S24: q = {raw[23:0], 8'h0};
      FMT_S32: q = raw;
      default: q = {raw[15:0], 16'h0};
    endcase
  end

endmodule

FILE: rtl/pbs_assemble.sv
// Byte assembly, channel tracking and frame building of the stereo converter.
module pbs_assemble import pbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  input  logic [2:0] fmt,
  input  logic [3:0] cnt,
  input  logic       cfg_clear,
  output frame_t     frame
);

  logic [23:0]         partial_r, partial_nxt;
  logic [1:0]          byte_idx_r, byte_idx_nxt;
  logic [CH_IDX_W-1:0] ch_idx_r, ch_idx_nxt;
  sample_t             held_left_r, held_left_nxt;
  sample_t             held_right_r, held_right_nxt;

  logic [2:0]    bps;
  logic [CH_W-1:0] ch;
  logic [1:0]    last_pos;
  logic          sample_done;
  logic          frame_done;
  logic          is_left;
  logic          is_right;
  logic [31:0]   raw;
  logic [31:0]   merged;
  sample_t       q;

  // Place the incoming byte and decide what it completes
  always_comb begin
    bps         = bytes_per_sample(fmt);
    ch          = channels_in_use(cnt);
    last_pos    = bps[1:0] - 2'd1;
    sample_done = ({1'b0, byte_idx_r} + 3'd1) >= bps;
    raw         = {8'h0, partial_r} | ({24'h0, data_byte} << {last_pos, 3'b000});
    merged      = {8'h0, partial_r} | ({24'h0, data_byte} << {byte_idx_r, 3'b000});
    frame_done  = ({{(CH_W-CH_IDX_W){1'b0}}, ch_idx_r} + CH_W'(1)) >= ch;
    is_left     = ch_idx_r == CH_IDX_W'(0);
    is_right    = (ch_idx_r == CH_IDX_W'(1)) || (ch == CH_W'(1));
  end

  pbs_to_q31 u_q31 (
    .fmt (fmt),
    .raw (raw),
    .q   (q)
  );

  // Advance the assembly state
  always_comb begin
    partial_nxt    = partial_r;
    byte_idx_nxt   = byte_idx_r;
    ch_idx_nxt     = ch_idx_r;
    held_left_nxt  = held_left_r;
    held_right_nxt = held_right_r;
    if (accept) begin
      if (!sample_done) begin
        partial_nxt  = merged[23:0];
        byte_idx_nxt = byte_idx_r + 2'd1;
      end else begin
        partial_nxt  = '0;
        byte_idx_nxt = '0;
        if (is_left) begin
          held_left_nxt = q;
        end
        if (is_right) begin
          held_right_nxt = q;
        end
        ch_idx_nxt = frame_done ? '0 : ch_idx_r + CH_IDX_W'(1);
      end
      if (buffer_end) begin
        partial_nxt  = '0;
        byte_idx_nxt = '0;
        ch_idx_nxt   = '0;
      end
    end
    if (cfg_clear) begin
      partial_nxt  = '0;
      byte_idx_nxt = '0;
      ch_idx_nxt   = '0;
    end
  end

  // Drive the finished frame
  always_comb begin
    frame.emit  = accept && sample_done && frame_done;
    frame.left  = is_left ? q : held_left_r;
    frame.right = is_right ? q : held_right_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r    <= '0;
      byte_idx_r   <= '0;
      ch_idx_r     <= '0;
      held_left_r  <= '0;
      held_right_r <= '0;
    end else begin
      partial_r    <= partial_nxt;
      byte_idx_r   <= byte_idx_nxt;
      ch_idx_r     <= ch_idx_nxt;
      held_left_r  <= held_left_nxt;
      held_right_r <= held_right_nxt;
    end
  end

endmodule

FILE: rtl/pcm_byte_stream_to_stereo.sv
// Top level of the PCM byte stream to stereo Q1.31 converter.
//
// Input channel: one byte of a little-endian PCM buffer per item, with a flag
// that marks the last byte of the buffer; any incomplete sample or frame is
// dropped after that byte is processed.
// Result channel: one left/right pair in Q1.31 per completed interleaved frame.
// Configuration channel: register 0 is the sample format, register 1 the
// channel count; a write clears the partial sample and frame. cfg_ready is
// always high; write only while the stream is idle.
// Throughput: one byte per cycle while no stalled result blocks in_ready, set
// by the single pass from the assembly registers through format scaling into
// the output register. The frame appears on out_valid in the cycle after its
// last byte is taken.
// Reset: format signed16, two channels, assembly and held samples cleared,
// no result pending.
// Stall: a pending result holds in the output register; a new byte is taken
// only while that register is empty or being emptied in the same cycle.
module pcm_byte_stream_to_stereo import pbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_buffer_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sample_t               out_left_sample,
  output sample_t               out_right_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0] fmt_r, fmt_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    left_r, left_nxt;
  sample_t    right_r, right_nxt;
  logic       accept;
  logic       cfg_clear;
  frame_t     frame;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  // Take register writes; ignore indexes beyond the list
  always_comb begin
    fmt_nxt   = fmt_r;
    cnt_nxt   = cnt_r;
    cfg_clear = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SAMPLE_FORMAT: begin
          fmt_nxt   = cfg_data[2:0];
          cfg_clear = 1'b1;
        end
        CFG_CHANNEL_COUNT: begin
          cnt_nxt   = cfg_data[3:0];
          cfg_clear = 1'b1;
        end
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  pbs_assemble u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .fmt        (fmt_r),
    .cnt        (cnt_r),
    .cfg_clear  (cfg_clear),
    .frame      (frame)
  );

  // Load a new frame or drop the delivered one
  always_comb begin
    out_valid_nxt = out_valid_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    if (accept) begin
      out_valid_nxt = frame.emit;
      left_nxt      = frame.left;
      right_nxt     = frame.right;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_S16;
      cnt_r       <= 4'd2;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

endmodule

FILE: rtl/pbs_checker.sv
// Port-level checks of the stereo converter and their binding to the top level.
`include "pcm_byte_stream_to_stereo_defines.svh"

module pbs_checker import pbs_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_left_sample,
  input sample_t out_right_sample
);

  // No result is pending right after reset
  `PBS_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // A stalled result holds its samples
  `PBS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_left_sample) && $stable(out_right_sample))

  // No byte is taken while a result is stalled
  `PBS_ASSERT_NOW(a_no_take_on_stall, out_valid && !out_ready, !in_ready)

  // A result only follows a taken byte
  `PBS_ASSERT_NEXT(a_no_invented, !out_valid && !(in_valid && in_ready), !out_valid)

endmodule

bind pcm_byte_stream_to_stereo pbs_checker u_pbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_left_sample  (out_left_sample),
  .out_right_sample (out_right_sample)
);
